// File: rtl/ghst_pkg.sv
// ----------------------------------------------------------------------------
// ghst_pkg
// shared constants, codes and types of the generational handle slot table
// ----------------------------------------------------------------------------
package ghst_pkg;

   localparam int SLOT_COUNT = 64;
   localparam int IDX_W      = $clog2(SLOT_COUNT);
   localparam int USED_W     = $clog2(SLOT_COUNT + 1);

   localparam int OBJ_W      = 32;
   localparam int VER_W      = 16;
   localparam int INDEX_W    = 16;
   localparam int SCENE_W    = 8;
   localparam int FREED_W    = 7;
   localparam int OP_W       = 2;
   localparam int STATUS_W   = 2;

   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 72;

   localparam logic [OP_W-1:0] OP_REGISTER   = 2'd0;
   localparam logic [OP_W-1:0] OP_UNREGISTER = 2'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP     = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;
   localparam logic [STATUS_W-1:0] ST_MISS    = 2'd3;

   localparam logic [VER_W-1:0]   VER_ONE    = {{(VER_W-1){1'b0}}, 1'b1};
   localparam logic [FREED_W-1:0] FREED_ONE  = {{(FREED_W-1){1'b0}}, 1'b1};

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_DRAIN
   } state_type;

   // request traveling down the row of slot cells
   typedef struct packed {
      logic                  valid;
      logic [OP_W-1:0]       op;
      logic                  act;
      logic [OBJ_W-1:0]      obj;
      logic [INDEX_W-1:0]    idx;
      logic [VER_W-1:0]      ver;
      logic [USED_W-1:0]     used;
      logic                  placed;
      logic                  appended;
      logic [INDEX_W-1:0]    o_index;
      logic [VER_W-1:0]      o_version;
      logic [OBJ_W-1:0]      o_object;
      logic [FREED_W-1:0]    freed;
   } token_type;

endpackage

// File: rtl/ghst_cell.sv
// ----------------------------------------------------------------------------
// ghst_cell
// one slot of the table: holds object id and version, acts on a passing word
// ----------------------------------------------------------------------------
module ghst_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [ghst_pkg::IDX_W-1:0]  cell_id,
   input  ghst_pkg::token_type         tok_in,
   output ghst_pkg::token_type         tok_out
);

   logic [ghst_pkg::OBJ_W-1:0] obj_ff;
   logic [ghst_pkg::OBJ_W-1:0] obj_in;
   logic [ghst_pkg::VER_W-1:0] ver_ff;
   logic [ghst_pkg::VER_W-1:0] ver_in;
   ghst_pkg::token_type        pass_ff;
   ghst_pkg::token_type        pass_in;

   logic                         in_use;
   logic                         at_tail;
   logic                         hit_idx;
   logic [ghst_pkg::INDEX_W-1:0] id_wide;

   always_comb begin
      id_wide = {{(ghst_pkg::INDEX_W - ghst_pkg::IDX_W){1'b0}}, cell_id};
      in_use  = {1'b0, cell_id} < tok_in.used;
      at_tail = {1'b0, cell_id} == tok_in.used;
      hit_idx = tok_in.idx == id_wide;
      obj_in  = obj_ff;
      ver_in  = ver_ff;
      pass_in = tok_in;
      if (tok_in.valid && tok_in.act) begin
         case (tok_in.op)
            ghst_pkg::OP_REGISTER: begin
               if (!tok_in.placed) begin
                  if (in_use && obj_ff == '0) begin
                     obj_in            = tok_in.obj;
                     pass_in.placed    = 1'b1;
                     pass_in.o_index   = id_wide;
                     pass_in.o_version = ver_ff;
                  end else if (at_tail) begin
                     obj_in            = tok_in.obj;
                     ver_in            = ghst_pkg::VER_ONE;
                     pass_in.placed    = 1'b1;
                     pass_in.appended  = 1'b1;
                     pass_in.o_index   = id_wide;
                     pass_in.o_version = ghst_pkg::VER_ONE;
                  end
               end
            end
            ghst_pkg::OP_UNREGISTER: begin
               if (in_use && obj_ff == tok_in.obj) begin
                  obj_in        = '0;
                  ver_in        = ver_ff + ghst_pkg::VER_ONE;
                  pass_in.freed = tok_in.freed + ghst_pkg::FREED_ONE;
               end
            end
            ghst_pkg::OP_LOOKUP: begin
               if (in_use && hit_idx && ver_ff == tok_in.ver && obj_ff != '0) begin
                  pass_in.o_object = obj_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      obj_ff <= obj_in;
      ver_ff <= ver_in;
      if (reset) begin
         pass_ff <= '0;
      end else begin
         pass_ff <= pass_in;
      end
   end

   assign tok_out = pass_ff;

endmodule

// File: rtl/generational_handle_slot_table.sv
// ----------------------------------------------------------------------------
// generational_handle_slot_table
// table of object slots with versioned handles, built as a row of slot cells
// ----------------------------------------------------------------------------
// requests arrive as words on the req_ stream: tuser carries the operation
// (register, unregister, lookup), tdata the object id and handle fields.
// each request yields exactly one response word on the rsp_ stream, with the
// status in tuser and index, version, object id and freed count in tdata.
// a request enters the first slot cell and moves one cell per cycle; each
// cell checks and updates its own slot as the word passes. one request is in
// the row at a time: a request passes every slot cell, then the holding
// register, then the response register, and the next request is taken on the
// cycle after its response is loaded. the response sits in an output
// register: if the receiver stalls, the next request is still accepted and
// worked on, and its result waits in a holding register until the output
// register frees.
// csr_we writes the owner scene id, which lookups must match (reset value 1).
// reset empties the table (no slots in use) and drops any request in flight;
// slot contents are not cleared since slots beyond the in-use count are
// never read.
// ----------------------------------------------------------------------------
module generational_handle_slot_table (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // object_id, slot_index, handle_version, scene_id
   input  logic [ghst_pkg::REQ_DATA_W-1:0]     req_tdata,
   // op
   input  logic [ghst_pkg::OP_W-1:0]           req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_index, out_version, out_object_id, freed_count, zero pad
   output logic [ghst_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // status
   output logic [ghst_pkg::STATUS_W-1:0]       rsp_tuser,
   input  logic                                csr_we,
   input  logic [ghst_pkg::SCENE_W-1:0]        csr_wdata
);

   localparam int PAD_W = ghst_pkg::RSP_DATA_W - 2 * ghst_pkg::INDEX_W
                          - ghst_pkg::OBJ_W - ghst_pkg::FREED_W;

   ghst_pkg::state_type state_ff;
   ghst_pkg::state_type state_in;

   logic [ghst_pkg::SCENE_W-1:0]  scene_ff;
   logic [ghst_pkg::USED_W-1:0]   used_ff;
   logic [ghst_pkg::USED_W-1:0]   used_in;

   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [ghst_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic [ghst_pkg::RSP_DATA_W-1:0] rsp_data_in;
   logic [ghst_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [ghst_pkg::STATUS_W-1:0] rsp_status_in;

   logic [ghst_pkg::RSP_DATA_W-1:0] pend_data_ff;
   logic [ghst_pkg::RSP_DATA_W-1:0] pend_data_in;
   logic [ghst_pkg::STATUS_W-1:0] pend_status_ff;
   logic [ghst_pkg::STATUS_W-1:0] pend_status_in;

   ghst_pkg::token_type chain [ghst_pkg::SLOT_COUNT+1];
   ghst_pkg::token_type launch;
   ghst_pkg::token_type done;

   logic [ghst_pkg::OBJ_W-1:0]    req_obj;
   logic [ghst_pkg::INDEX_W-1:0]  req_idx;
   logic [ghst_pkg::VER_W-1:0]    req_ver;
   logic [ghst_pkg::SCENE_W-1:0]  req_scene;
   logic                          accept;
   logic                          out_free;
   logic [ghst_pkg::STATUS_W-1:0] done_status;

   assign req_obj   = req_tdata[ghst_pkg::OBJ_W-1:0];
   assign req_idx   = req_tdata[ghst_pkg::OBJ_W +: ghst_pkg::INDEX_W];
   assign req_ver   = req_tdata[ghst_pkg::OBJ_W + ghst_pkg::INDEX_W +: ghst_pkg::VER_W];
   assign req_scene = req_tdata[ghst_pkg::OBJ_W + ghst_pkg::INDEX_W + ghst_pkg::VER_W +:
                                ghst_pkg::SCENE_W];

   assign req_tready = state_ff == ghst_pkg::S_IDLE;
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // request word entering the row
   always_comb begin
      launch           = '0;
      launch.valid     = accept;
      launch.op        = req_tuser;
      launch.obj       = req_obj;
      launch.idx       = req_idx;
      launch.ver       = req_ver;
      launch.used      = used_ff;
      case (req_tuser) inside
         ghst_pkg::OP_REGISTER,
         ghst_pkg::OP_UNREGISTER: launch.act = req_obj != '0;
         ghst_pkg::OP_LOOKUP:     launch.act = req_scene != '0 && req_scene == scene_ff;
         default:                 launch.act = 1'b0;
      endcase
   end

   assign chain[0] = launch;

   for (genvar i = 0; i < ghst_pkg::SLOT_COUNT; i++) begin : g_cell
      localparam logic [31:0] ID = 32'(i);
      ghst_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .cell_id (ID[ghst_pkg::IDX_W-1:0]),
         .tok_in  (chain[i]),
         .tok_out (chain[i+1])
      );
   end

   assign done = chain[ghst_pkg::SLOT_COUNT];

   always_comb begin
      case (done.op)
         ghst_pkg::OP_REGISTER: begin
            if (!done.act)        done_status = ghst_pkg::ST_INVALID;
            else if (done.placed) done_status = ghst_pkg::ST_OK;
            else                  done_status = ghst_pkg::ST_FULL;
         end
         ghst_pkg::OP_UNREGISTER: begin
            if (!done.act)          done_status = ghst_pkg::ST_INVALID;
            else if (done.freed != '0) done_status = ghst_pkg::ST_OK;
            else                    done_status = ghst_pkg::ST_MISS;
         end
         ghst_pkg::OP_LOOKUP: begin
            done_status = (done.o_object != '0) ? ghst_pkg::ST_OK : ghst_pkg::ST_MISS;
         end
         default: done_status = ghst_pkg::ST_MISS;
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      used_in        = used_ff;
      pend_data_in   = pend_data_ff;
      pend_status_in = pend_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      rsp_status_in  = rsp_status_ff;
      unique case (state_ff)
         ghst_pkg::S_IDLE: begin
            if (accept) begin
               state_in = ghst_pkg::S_RUN;
            end
         end
         ghst_pkg::S_RUN: begin
            if (done.valid) begin
               pend_data_in   = {{PAD_W{1'b0}}, done.freed, done.o_object,
                                 done.o_version, done.o_index};
               pend_status_in = done_status;
               if (done.appended) begin
                  used_in = used_ff + {{(ghst_pkg::USED_W-1){1'b0}}, 1'b1};
               end
               state_in = ghst_pkg::S_DRAIN;
            end
         end
         ghst_pkg::S_DRAIN: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = pend_data_ff;
               rsp_status_in = pend_status_ff;
               state_in      = ghst_pkg::S_IDLE;
            end
         end
         default: state_in = ghst_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      pend_data_ff   <= pend_data_in;
      pend_status_ff <= pend_status_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_status_ff  <= rsp_status_in;
      if (reset) begin
         state_ff     <= ghst_pkg::S_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         scene_ff     <= {{(ghst_pkg::SCENE_W-1){1'b0}}, 1'b1};
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            scene_ff <= csr_wdata;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// directed and random test of the generational handle slot table
// ----------------------------------------------------------------------------
// a scoreboard keeps its own copy of the slot table. it predicts the response
// word of every accepted request and compares the responses in order.
// the run uses several owner scene ids and three idling patterns. one long
// receiver stall backs up the request stream.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int NPOOL       = 16;

   typedef logic [ghst_pkg::OBJ_W-1:0]    object_type;
   typedef logic [ghst_pkg::VER_W-1:0]    version_type;
   typedef logic [ghst_pkg::INDEX_W-1:0]  index_type;
   typedef logic [ghst_pkg::SCENE_W-1:0]  scene_type;
   typedef logic [ghst_pkg::OP_W-1:0]     op_type;
   typedef logic [ghst_pkg::STATUS_W-1:0] status_type;
   typedef logic [ghst_pkg::IDX_W-1:0]    slot_type;
   typedef logic [3:0]                    pool_index_type;

   typedef struct packed {
      scene_type   scene;
      version_type version;
      index_type   slot_idx;
      object_type  obj_id;
   } req_fields_type;

   typedef struct packed {
      logic                         zero_pad;
      logic [ghst_pkg::FREED_W-1:0] freed;
      object_type                   obj_id;
      version_type                  version;
      index_type                    slot_idx;
   } rsp_fields_type;

   typedef struct packed {
      status_type     status;
      rsp_fields_type fields;
   } reply_type;

   class slot_table_scoreboard_type;
      object_type  slot_obj [ghst_pkg::SLOT_COUNT];
      version_type slot_ver [ghst_pkg::SLOT_COUNT];
      int unsigned used;
      scene_type   own_scene;
      reply_type   awaited [$];
      int unsigned errors;

      function new();
         used      = 0;
         own_scene = 8'd1;
         errors    = 0;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function bit has_empty();
         int i;
         for (i = 0; i < used; i++)
            if (slot_obj[slot_type'(i)] == '0) return 1'b1;
         return 1'b0;
      endfunction

      function void note_request(op_type op, req_fields_type f);
         reply_type r;
         int        i;
         int        hit;
         r.status = ghst_pkg::ST_MISS;
         r.fields = '0;
         case (op)
            ghst_pkg::OP_REGISTER: begin
               if (f.obj_id == '0) begin
                  r.status = ghst_pkg::ST_INVALID;
               end else begin
                  hit = -1;
                  for (i = 0; i < used && hit < 0; i++)
                     if (slot_obj[slot_type'(i)] == '0) hit = i;
                  if (hit < 0 && used < ghst_pkg::SLOT_COUNT) begin
                     hit = int'(used);
                     slot_ver[slot_type'(hit)] = ghst_pkg::VER_ONE;
                     used++;
                  end
                  if (hit < 0) begin
                     r.status = ghst_pkg::ST_FULL;
                  end else begin
                     slot_obj[slot_type'(hit)] = f.obj_id;
                     r.status                  = ghst_pkg::ST_OK;
                     r.fields.slot_idx         = index_type'(hit);
                     r.fields.version          = slot_ver[slot_type'(hit)];
                  end
               end
            end
            ghst_pkg::OP_UNREGISTER: begin
               if (f.obj_id == '0) begin
                  r.status = ghst_pkg::ST_INVALID;
               end else begin
                  for (i = 0; i < used; i++) begin
                     if (slot_obj[slot_type'(i)] == f.obj_id) begin
                        slot_obj[slot_type'(i)] = '0;
                        slot_ver[slot_type'(i)] = slot_ver[slot_type'(i)]
                                                  + ghst_pkg::VER_ONE;
                        r.fields.freed = r.fields.freed + ghst_pkg::FREED_ONE;
                     end
                  end
                  r.status = (r.fields.freed != '0) ? ghst_pkg::ST_OK : ghst_pkg::ST_MISS;
               end
            end
            ghst_pkg::OP_LOOKUP: begin
               if (f.scene != '0 && f.scene == own_scene && f.slot_idx < used
                   && slot_ver[f.slot_idx[ghst_pkg::IDX_W-1:0]] == f.version
                   && slot_obj[f.slot_idx[ghst_pkg::IDX_W-1:0]] != '0) begin
                  r.status        = ghst_pkg::ST_OK;
                  r.fields.obj_id = slot_obj[f.slot_idx[ghst_pkg::IDX_W-1:0]];
               end
            end
            default: ;  // unused op code
         endcase
         awaited.insert(awaited.size(), r);
      endfunction

      task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
         errors++;
         if (errors <= 40)
            $display("%0t mismatch in %s: got %0h, expected %0h", $time, what, got, want);
      endtask

      task check_response(status_type status, rsp_fields_type got);
         reply_type want;
         if (awaited.size() == 0) begin
            report_mismatch("response with none pending", 64'(status), 64'(0));
            return;
         end
         want = awaited.pop_front();
         if (status !== want.status)
            report_mismatch("status", 64'(status), 64'(want.status));
         if (got.slot_idx !== want.fields.slot_idx)
            report_mismatch("out_index", 64'(got.slot_idx), 64'(want.fields.slot_idx));
         if (got.version !== want.fields.version)
            report_mismatch("out_version", 64'(got.version), 64'(want.fields.version));
         if (got.obj_id !== want.fields.obj_id)
            report_mismatch("out_object_id", 64'(got.obj_id), 64'(want.fields.obj_id));
         if (got.freed !== want.fields.freed)
            report_mismatch("freed_count", 64'(got.freed), 64'(want.fields.freed));
         if (got.zero_pad !== 1'b0)
            report_mismatch("pad bit", 64'(got.zero_pad), 64'(0));
      endtask
   endclass

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   // object_id, slot_index, handle_version, scene_id
   logic [ghst_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   op_type                          req_tuser  = '0;  // op
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   // out_index, out_version, out_object_id, freed_count
   logic [ghst_pkg::RSP_DATA_W-1:0] rsp_tdata;
   status_type                      rsp_tuser;        // status
   logic                            csr_we     = 1'b0;
   scene_type                       csr_wdata  = '0;

   logic                      sink_hold     = 1'b0;
   int unsigned               sink_idle_pct = 0;
   int unsigned               src_idle_pct  = 0;
   int unsigned               items_sent    = 0;
   int unsigned               cycle_count   = 0;
   object_type                id_pool [NPOOL];
   slot_table_scoreboard_type sb = new();

   generational_handle_slot_table u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tuser, rsp_tdata);
      rsp_tready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   task automatic send_item(input op_type op, input req_fields_type f);
      while ($urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= f;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(op, f);
      items_sent++;
   endtask

   task automatic send_object_op(input op_type op, input object_type id);
      req_fields_type f;
      f        = '0;
      f.obj_id = id;
      send_item(op, f);
   endtask

   task automatic send_lookup(input index_type idx, input version_type ver,
                              input scene_type scene);
      req_fields_type f;
      f          = '0;
      f.slot_idx = idx;
      f.version  = ver;
      f.scene    = scene;
      send_item(ghst_pkg::OP_LOOKUP, f);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_scene(input scene_type v);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we       <= 1'b0;
      sb.own_scene  = v;
   endtask

   task automatic stall_receiver(input int unsigned cycles);
      fork
         begin
            sink_hold <= 1'b1;
            repeat (cycles) @(posedge clock);
            sink_hold <= 1'b0;
         end
      join_none
   endtask

   function automatic object_type pick_id();
      object_type id;
      id = $urandom;
      if ($urandom_range(99) < 85) id = id_pool[pool_index_type'($urandom_range(NPOOL-1))];
      else if ($urandom_range(99) < 10) id = '0;
      return id;
   endfunction

   task automatic random_lookup();
      index_type   idx;
      version_type ver;
      scene_type   scene;
      int unsigned k;
      k = $urandom_range(99);
      if (sb.used != 0 && k < 80) begin
         idx   = index_type'($urandom_range(sb.used - 1));
         ver   = sb.slot_ver[idx[ghst_pkg::IDX_W-1:0]];
         scene = sb.own_scene;
         if (k < 12)
            ver = ver + ghst_pkg::VER_ONE;
         else if (k < 18)
            ver = ver - ghst_pkg::VER_ONE;
         else if (k < 23)
            scene = scene_type'($urandom_range(255));
      end else if (k < 90) begin
         idx   = index_type'(sb.used + $urandom_range(2));
         ver   = ghst_pkg::VER_ONE;
         scene = sb.own_scene;
      end else begin
         idx   = index_type'($urandom_range(65535));
         ver   = version_type'($urandom_range(65535));
         scene = scene_type'($urandom_range(255));
      end
      send_lookup(idx, ver, scene);
   endtask

   task automatic send_noise();
      req_fields_type f;
      op_type         op;
      op         = op_type'($urandom_range(3));
      f.obj_id   = $urandom;
      f.slot_idx = index_type'($urandom_range(65535));
      f.version  = version_type'($urandom_range(65535));
      f.scene    = scene_type'($urandom_range(255));
      if ($urandom_range(3) == 0) f.obj_id = '0;
      send_item(op, f);
   endtask

   // register until every slot is taken, then push past full; when a single id did the filling, unregister it again
   task automatic fill_table();
      object_type id;
      bit         one_id;
      one_id = 1'($urandom_range(1));
      id     = id_pool[pool_index_type'($urandom_range(NPOOL-1))];
      while (sb.used < ghst_pkg::SLOT_COUNT || sb.has_empty())
         send_object_op(ghst_pkg::OP_REGISTER, one_id ? id : pick_id());
      repeat (2) send_object_op(ghst_pkg::OP_REGISTER, id);
      if (one_id) send_object_op(ghst_pkg::OP_UNREGISTER, id);
   endtask

   task automatic run_random(input int unsigned budget);
      int unsigned first;
      int unsigned kind;
      first = items_sent;
      fill_table();
      while (items_sent - first < budget) begin
         kind = $urandom_range(99);
         if (kind < 32)
            repeat ($urandom_range(16, 2)) send_object_op(ghst_pkg::OP_REGISTER, pick_id());
         else if (kind < 52)
            repeat ($urandom_range(4, 1)) send_object_op(ghst_pkg::OP_UNREGISTER, pick_id());
         else if (kind < 85)
            repeat ($urandom_range(8, 2)) random_lookup();
         else if (kind < 88)
            fill_table();
         else
            send_noise();
      end
   endtask

   initial begin
      int i;
      for (i = 0; i < NPOOL; i++)
         id_pool[pool_index_type'(i)] = (i < 6) ? object_type'(i + 1) : ($urandom | 32'h1);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table, invalid ids, duplicates, stale and foreign handles
      send_lookup(16'd0, ghst_pkg::VER_ONE, 8'd1);
      send_object_op(ghst_pkg::OP_REGISTER, 32'd0);
      send_object_op(ghst_pkg::OP_UNREGISTER, 32'd0);
      send_object_op(ghst_pkg::OP_UNREGISTER, 32'd5);
      send_object_op(ghst_pkg::OP_REGISTER, 32'hFFFF_FFFF);
      send_object_op(ghst_pkg::OP_REGISTER, 32'd1);
      send_object_op(ghst_pkg::OP_REGISTER, 32'hFFFF_FFFF);
      send_lookup(16'd0, ghst_pkg::VER_ONE, 8'd1);
      send_lookup(16'd0, ghst_pkg::VER_ONE, 8'd0);
      send_lookup(16'd0, ghst_pkg::VER_ONE, 8'd2);
      send_lookup(16'd0, 16'd2, 8'd1);
      send_lookup(16'hFFFF, 16'hFFFF, 8'hFF);
      send_object_op(ghst_pkg::OP_UNREGISTER, 32'hFFFF_FFFF);
      send_lookup(16'd0, ghst_pkg::VER_ONE, 8'd1);
      send_lookup(16'd0, 16'd2, 8'd1);
      send_object_op(ghst_pkg::OP_REGISTER, 32'h8000_0000);
      send_item(op_type'($urandom_range(3, 3)), '1);
      send_lookup(16'd3, ghst_pkg::VER_ONE, 8'd1);
      send_lookup(16'd1, ghst_pkg::VER_ONE, 8'd1);
      write_scene(8'd255);
      send_lookup(16'd1, ghst_pkg::VER_ONE, 8'd255);
      send_lookup(16'd1, ghst_pkg::VER_ONE, 8'd1);

      write_scene(scene_type'($urandom_range(254, 2)));
      src_idle_pct   = 7;
      sink_idle_pct <= 81;
      run_random(240);

      write_scene(8'd1);
      src_idle_pct   = 81;
      sink_idle_pct <= 7;
      run_random(240);

      write_scene(8'd255);
      src_idle_pct   = 0;
      sink_idle_pct <= 0;
      stall_receiver(600);
      run_random(250);

      wait_drained();
      repeat (80) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule

// File: sim.f
rtl/ghst_pkg.sv
rtl/ghst_cell.sv
rtl/generational_handle_slot_table.sv
sim/testbench.sv
